// ===== rtl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg: shared types and constants for the register bytecode executor
// Sizes, opcode codes and the structs passed between the executor's parts.
// ----------------------------------------------------------------------------
package rbe_pkg;

  localparam int REG_COUNT   = 256;
  localparam int REG_WIDTH   = 32;
  localparam int HEAP_BYTES  = 256;
  localparam int TEXT_BYTES  = 8192;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int HEAP_ADDR_W = $clog2(HEAP_BYTES);
  localparam int PC_W        = $clog2(TEXT_BYTES);
  localparam int FIELD_W     = 8;
  localparam int PC_STEP     = 4;

  typedef enum logic [FIELD_W-1:0] {
    OP_HALT  = 8'h00,
    OP_LOAD  = 8'h10,
    OP_STORE = 8'h20,
    OP_MOVE  = 8'h30,
    OP_PUTI  = 8'h40,
    OP_ADD   = 8'h50,
    OP_SUB   = 8'h60,
    OP_GT    = 8'h70,
    OP_GE    = 8'h80,
    OP_EQ    = 8'h90,
    OP_ITE   = 8'ha0,
    OP_JUMP  = 8'hb0
  } opcode_t;

  // One decoded instruction word
  typedef struct packed {
    logic [FIELD_W-1:0] opcode;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
  } instr_t;

  // Everything one executed word changes or reports
  typedef struct packed {
    logic [PC_W-1:0]        npc;
    logic                   halt_set;
    logic                   bad;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   wr_idx;
    logic [REG_WIDTH-1:0]   wr_val;
    logic                   heap_we;
    logic [HEAP_ADDR_W-1:0] heap_addr;
    logic [7:0]             heap_data;
  } exec_res_t;

endpackage

// ===== rtl/register_bytecode_executor.sv =====
// Flow: an accepted word waits in stage 1, and its result is then registered
//   on the outputs; a stalled result register holds stage 1 back.
// Throughput: one word per cycle while out_stall is low, limited by the single execute stage;
//   the register file and heap read at accept and write at execute.
// Reset (rst_n low, synchronous): pc, halted flag, pipeline valids and the
//   valid bits of the register file and heap clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// register_bytecode_executor: single-issue register bytecode executor
// Executes one 32-bit instruction word per input word and reports the next
// pc, status flags and the register write of that word.
// ----------------------------------------------------------------------------
module register_bytecode_executor (
  input  logic        clk,
  input  logic        rst_n,
  // instruction words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_field_a,
  input  logic [7:0]  in_field_b,
  input  logic [7:0]  in_field_c,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_next_pc,
  output logic        out_halted,
  output logic        out_bad_opcode,
  output logic        out_reg_written,
  output logic [7:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_heap_written
);

  // --------------------------------------------------------------------------
  // Stage 1: accepted word plus its operand reads (read data sits in the
  // memories' output registers). Stage 2: result register.
  // --------------------------------------------------------------------------
  logic                        in_fire;
  logic                        s1_adv;
  logic                        s1_fire;
  logic                        s1_valid_r, s1_valid_nxt;
  rbe_pkg::instr_t             s1_instr_r;

  logic [rbe_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic                        halted_r, halted_nxt;

  logic [rbe_pkg::REG_IDX_W-1:0]   rd0_addr;
  logic [rbe_pkg::REG_WIDTH-1:0]   rp0, rp1;
  logic [7:0]                      hbyte;
  rbe_pkg::exec_res_t              res;

  logic        out_valid_r, out_valid_nxt;
  logic [12:0] out_next_pc_r;
  logic        out_halted_r;
  logic        out_bad_r;
  logic        out_reg_written_r;
  logic [7:0]  out_reg_index_r;
  logic [31:0] out_reg_value_r;
  logic        out_heap_written_r;

  // Stage 1 moves on whenever the result register is free or being drained,
  // so a new word is taken while an older result still waits.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  // ite tests reg[a]; all other users of port 0 want reg[b]
  assign rd0_addr = (in_opcode == rbe_pkg::OP_ITE) ?
                    in_field_a[rbe_pkg::REG_IDX_W-1:0] :
                    in_field_b[rbe_pkg::REG_IDX_W-1:0];

  rbe_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd0_addr (rd0_addr),
    .rd1_addr (in_field_c[rbe_pkg::REG_IDX_W-1:0]),
    .rd0_data (rp0),
    .rd1_data (rp1),
    .we       (s1_fire && res.wr_en),
    .waddr    (res.wr_idx),
    .wdata    (res.wr_val)
  );

  rbe_heap u_heap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_field_b[rbe_pkg::HEAP_ADDR_W-1:0]),
    .rd_data (hbyte),
    .we      (s1_fire && res.heap_we),
    .waddr   (res.heap_addr),
    .wdata   (res.heap_data)
  );

  rbe_exec u_exec (
    .instr  (s1_instr_r),
    .pc     (pc_r),
    .halted (halted_r),
    .rp0    (rp0),
    .rp1    (rp1),
    .hbyte  (hbyte),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    if (s1_fire) begin
      pc_nxt     = res.npc;
      halted_nxt = halted_r || res.halt_set;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pc_r        <= pc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= '{opcode: in_opcode, a: in_field_a, b: in_field_b, c: in_field_c};
    end
    if (s1_fire) begin
      out_next_pc_r      <= 13'(res.npc);
      out_halted_r       <= halted_r || res.halt_set;
      out_bad_r          <= res.bad;
      out_reg_written_r  <= res.wr_en;
      out_reg_index_r    <= res.wr_en ? 8'(res.wr_idx) : 8'h00;
      out_reg_value_r    <= res.wr_en ? 32'(res.wr_val) : 32'h0;
      out_heap_written_r <= res.heap_we;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_next_pc_r;
  assign out_halted       = out_halted_r;
  assign out_bad_opcode   = out_bad_r;
  assign out_reg_written  = out_reg_written_r;
  assign out_reg_index    = out_reg_index_r;
  assign out_reg_value    = out_reg_value_r;
  assign out_heap_written = out_heap_written_r;

endmodule

// ===== rtl/rbe_regfile.sv =====
// ----------------------------------------------------------------------------
// rbe_regfile: register file, two registered read ports, one write port
// Per-entry valid bits give the all-zero reset; last write is forwarded.
// ----------------------------------------------------------------------------
module rbe_regfile (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   rd_en,
  input  logic [rbe_pkg::REG_IDX_W-1:0]          rd0_addr,
  input  logic [rbe_pkg::REG_IDX_W-1:0]          rd1_addr,
  output logic [rbe_pkg::REG_WIDTH-1:0]          rd0_data,
  output logic [rbe_pkg::REG_WIDTH-1:0]          rd1_data,
  input  logic                                   we,
  input  logic [rbe_pkg::REG_IDX_W-1:0]          waddr,
  input  logic [rbe_pkg::REG_WIDTH-1:0]          wdata
);

  logic [rbe_pkg::REG_WIDTH-1:0] mem [rbe_pkg::REG_COUNT];
  logic [rbe_pkg::REG_COUNT-1:0] valid_r;

  logic [rbe_pkg::REG_WIDTH-1:0] q0_r, q1_r;
  logic                          v0_r, v1_r;
  logic [rbe_pkg::REG_IDX_W-1:0] a0_r, a1_r;

  // most recent write; covers a read taken on the same edge as that write
  logic                          fwd_v_r;
  logic [rbe_pkg::REG_IDX_W-1:0] fwd_addr_r;
  logic [rbe_pkg::REG_WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0_r <= mem[rd0_addr];
      q1_r <= mem[rd1_addr];
      a0_r <= rd0_addr;
      a1_r <= rd1_addr;
    end
    if (we) begin
      fwd_addr_r <= waddr;
      fwd_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (rd_en) begin
        v0_r <= valid_r[rd0_addr];
        v1_r <= valid_r[rd1_addr];
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
        fwd_v_r        <= 1'b1;
      end
    end
  end

  always_comb begin
    if (fwd_v_r && (fwd_addr_r == a0_r)) begin
      rd0_data = fwd_data_r;
    end else begin
      rd0_data = v0_r ? q0_r : '0;
    end
    if (fwd_v_r && (fwd_addr_r == a1_r)) begin
      rd1_data = fwd_data_r;
    end else begin
      rd1_data = v1_r ? q1_r : '0;
    end
  end

endmodule

// ===== rtl/rbe_heap.sv =====
// ----------------------------------------------------------------------------
// rbe_heap: byte data heap, one registered read port, one write port
// Per-entry valid bits give the all-zero reset; last store is forwarded.
// ----------------------------------------------------------------------------
module rbe_heap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [rbe_pkg::HEAP_ADDR_W-1:0]   rd_addr,
  output logic [7:0]                        rd_data,
  input  logic                              we,
  input  logic [rbe_pkg::HEAP_ADDR_W-1:0]   waddr,
  input  logic [7:0]                        wdata
);

  logic [7:0]                      mem [rbe_pkg::HEAP_BYTES];
  logic [rbe_pkg::HEAP_BYTES-1:0]  valid_r;
  logic [7:0]                      q_r;
  logic                            v_r;
  logic [rbe_pkg::HEAP_ADDR_W-1:0] a_r;
  logic                            fwd_v_r;
  logic [rbe_pkg::HEAP_ADDR_W-1:0] fwd_addr_r;
  logic [7:0]                      fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
      a_r <= rd_addr;
    end
    if (we) begin
      fwd_addr_r <= waddr;
      fwd_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v_r     <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (rd_en) begin
        v_r <= valid_r[rd_addr];
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
        fwd_v_r        <= 1'b1;
      end
    end
  end

  always_comb begin
    if (fwd_v_r && (fwd_addr_r == a_r)) begin
      rd_data = fwd_data_r;
    end else begin
      rd_data = v_r ? q_r : 8'h00;
    end
  end

endmodule

// ===== rtl/rbe_exec.sv =====
// ----------------------------------------------------------------------------
// rbe_exec: instruction execute logic
// Decodes one word against its operands and produces all state updates.
// ----------------------------------------------------------------------------
module rbe_exec (
  input  rbe_pkg::instr_t                 instr,
  input  logic [rbe_pkg::PC_W-1:0]        pc,
  input  logic                            halted,
  input  logic [rbe_pkg::REG_WIDTH-1:0]   rp0,   // reg[b], or reg[a] for ite
  input  logic [rbe_pkg::REG_WIDTH-1:0]   rp1,   // reg[c]
  input  logic [7:0]                      hbyte, // heap[b]
  output rbe_pkg::exec_res_t              res
);

  always_comb begin
    res           = '0;
    res.npc       = pc + rbe_pkg::PC_W'(rbe_pkg::PC_STEP);
    res.wr_idx    = instr.a[rbe_pkg::REG_IDX_W-1:0];
    res.heap_addr = instr.a[rbe_pkg::HEAP_ADDR_W-1:0];
    res.heap_data = rp0[7:0];
    if (halted) begin
      res.npc = pc;
    end else begin
      case (instr.opcode)
        rbe_pkg::OP_HALT: begin
          res.halt_set = 1'b1;
          res.npc      = pc;
        end
        rbe_pkg::OP_LOAD: begin
          res.wr_en  = 1'b1;
          res.wr_val = {{(rbe_pkg::REG_WIDTH-8){hbyte[7]}}, hbyte};
        end
        rbe_pkg::OP_STORE: res.heap_we = 1'b1;
        rbe_pkg::OP_MOVE: begin
          res.wr_en  = 1'b1;
          res.wr_val = rp0;
        end
        rbe_pkg::OP_PUTI: begin
          res.wr_en  = 1'b1;
          res.wr_val = rbe_pkg::REG_WIDTH'(instr.b);
        end
        rbe_pkg::OP_ADD: begin
          res.wr_en  = 1'b1;
          res.wr_val = rp0 + rp1;
        end
        rbe_pkg::OP_SUB: begin
          res.wr_en  = 1'b1;
          res.wr_val = rp0 - rp1;
        end
        rbe_pkg::OP_GT: begin
          res.wr_en  = 1'b1;
          res.wr_val = rbe_pkg::REG_WIDTH'(rp0 > rp1);
        end
        rbe_pkg::OP_GE: begin
          res.wr_en  = 1'b1;
          res.wr_val = rbe_pkg::REG_WIDTH'(rp0 >= rp1);
        end
        rbe_pkg::OP_EQ: begin
          res.wr_en  = 1'b1;
          res.wr_val = rbe_pkg::REG_WIDTH'(rp0 == rp1);
        end
        rbe_pkg::OP_ITE: begin
          res.npc = (rp0 != '0) ? rbe_pkg::PC_W'(instr.b) : rbe_pkg::PC_W'(instr.c);
        end
        rbe_pkg::OP_JUMP: res.npc = rbe_pkg::PC_W'(instr.a);
        default: begin
          res.bad = 1'b1;
          res.npc = pc;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rbe_checker.sv =====
// ----------------------------------------------------------------------------
// rbe_checker: port-level checks for the register bytecode executor
// Watches the result channel for stall holding, halt and status consistency.
// ----------------------------------------------------------------------------
module rbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_next_pc,
  input logic        out_halted,
  input logic        out_bad_opcode,
  input logic        out_reg_written,
  input logic [7:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic        out_heap_written
);

  logic        seen_halt_r;
  logic [12:0] halt_pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && !out_stall && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall && out_halted && !seen_halt_r) begin
      halt_pc_r <= out_next_pc;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc) && $stable(out_reg_value))
    else $error("stalled result word changed");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> out_halted && out_next_pc == halt_pc_r &&
    !out_reg_written && !out_heap_written && !out_bad_opcode)
    else $error("word after halt changed state");

  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_opcode |-> !out_reg_written && !out_heap_written && !out_halted)
    else $error("undefined opcode reported side effects");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_written |-> out_reg_index == 8'h00 && out_reg_value == 32'h0)
    else $error("register fields nonzero without write");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_reg_written && out_heap_written))
    else $error("register and heap written by one word");

endmodule

bind register_bytecode_executor rbe_checker u_rbe_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for register_bytecode_executor
// Streams instruction words through the executor while a shadow copy of its
// register file, heap and pc predicts every result word. Directed words hit
// the data, branch and undefined-opcode corners. Random short programs and a
// long straight-line run to high pc values follow. A halt comes last, since
// it sticks until reset. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  // One result word, laid out like the output ports
  typedef struct packed {
    logic [rbe_pkg::PC_W-1:0] next_pc;
    logic                     halted;
    logic                     bad_opcode;
    logic                     reg_written;
    logic [7:0]               reg_index;
    logic [31:0]              reg_value;
    logic                     heap_written;
  } step_result_t;

  // Opcodes the random code may use; halt is left out since it sticks.
  // The first nine never change the pc flow.
  localparam rbe_pkg::opcode_t RUN_OPS [11] = '{
    rbe_pkg::OP_LOAD, rbe_pkg::OP_STORE, rbe_pkg::OP_MOVE, rbe_pkg::OP_PUTI,
    rbe_pkg::OP_ADD, rbe_pkg::OP_SUB, rbe_pkg::OP_GT, rbe_pkg::OP_GE,
    rbe_pkg::OP_EQ, rbe_pkg::OP_ITE, rbe_pkg::OP_JUMP};
  localparam int STRAIGHT_OPS   = 9;
  localparam int RANDOM_WORDS   = 500;
  localparam int STRAIGHT_WORDS = 320;
  localparam logic [7:0] UNDEFINED_OPS [4] = '{8'h01, 8'hff, 8'hc0, 8'h5f};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_opcode = '0;
  logic [7:0]  in_field_a = '0;
  logic [7:0]  in_field_b = '0;
  logic [7:0]  in_field_c = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_next_pc;
  logic        out_halted;
  logic        out_bad_opcode;
  logic        out_reg_written;
  logic [7:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_heap_written;

  // Shadow machine state
  logic [rbe_pkg::REG_WIDTH-1:0] shadow_regs [rbe_pkg::REG_COUNT];
  logic [7:0]                    shadow_heap [rbe_pkg::HEAP_BYTES];
  logic [rbe_pkg::PC_W-1:0]      shadow_pc;
  logic                          shadow_halted;

  step_result_t pending_results [$];

  int  error_count = 0;
  int  words_sent = 0;
  int  undefined_sent = 0;
  int  results_checked = 0;
  bit  no_gaps = 1'b0;     // sender runs back to back while set
  int  stall_left = 0;     // receiver stall cycles still to go
  int  calm_left = 0;      // receiver stretch with no stalls
  int  roll;

  register_bytecode_executor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_field_a       (in_field_a),
    .in_field_b       (in_field_b),
    .in_field_c       (in_field_c),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_pc      (out_next_pc),
    .out_halted       (out_halted),
    .out_bad_opcode   (out_bad_opcode),
    .out_reg_written  (out_reg_written),
    .out_reg_index    (out_reg_index),
    .out_reg_value    (out_reg_value),
    .out_heap_written (out_heap_written)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h, expected %0h (result %0d)",
                             name, got, want, results_checked));
  endtask

  // Executes one word on the shadow state and queues the result it yields
  task automatic execute_word(input logic [7:0] op, a, b, c);
    step_result_t                  r;
    logic [rbe_pkg::REG_WIDTH-1:0] vb;
    logic [rbe_pkg::REG_WIDTH-1:0] vc;
    logic [rbe_pkg::PC_W-1:0]      npc;
    r   = '0;
    vb  = shadow_regs[b];
    vc  = shadow_regs[c];
    npc = shadow_pc + rbe_pkg::PC_W'(rbe_pkg::PC_STEP);   // wraps at the text size by width
    if (shadow_halted) begin
      npc = shadow_pc;
    end else begin
      case (op)
        rbe_pkg::OP_HALT: begin
          shadow_halted = 1'b1;
          npc = shadow_pc;
        end
        rbe_pkg::OP_LOAD: begin
          r.reg_written = 1'b1;
          r.reg_value = {{(rbe_pkg::REG_WIDTH-8){shadow_heap[b][7]}}, shadow_heap[b]};
        end
        rbe_pkg::OP_STORE: begin
          shadow_heap[a] = vb[7:0];
          r.heap_written = 1'b1;
        end
        rbe_pkg::OP_MOVE: begin r.reg_written = 1'b1; r.reg_value = vb; end
        rbe_pkg::OP_PUTI: begin r.reg_written = 1'b1; r.reg_value = 32'(b); end
        rbe_pkg::OP_ADD:  begin r.reg_written = 1'b1; r.reg_value = vb + vc; end
        rbe_pkg::OP_SUB:  begin r.reg_written = 1'b1; r.reg_value = vb - vc; end
        rbe_pkg::OP_GT:   begin r.reg_written = 1'b1; r.reg_value = (vb > vc) ? 1 : 0; end
        rbe_pkg::OP_GE:   begin r.reg_written = 1'b1; r.reg_value = (vb >= vc) ? 1 : 0; end
        rbe_pkg::OP_EQ:   begin r.reg_written = 1'b1; r.reg_value = (vb == vc) ? 1 : 0; end
        rbe_pkg::OP_ITE:
          npc = (shadow_regs[a] != '0) ? rbe_pkg::PC_W'(b) : rbe_pkg::PC_W'(c);
        rbe_pkg::OP_JUMP: npc = rbe_pkg::PC_W'(a);
        default: begin
          r.bad_opcode = 1'b1;
          npc = shadow_pc;
          undefined_sent++;
        end
      endcase
      if (r.reg_written) begin
        r.reg_index = a;
        shadow_regs[a] = r.reg_value;
      end
      shadow_pc = npc;
    end
    r.next_pc = npc;
    r.halted  = shadow_halted;
    pending_results.push_back(r);
  endtask

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Drives one word at the clock edge and holds it until accepted
  task automatic send_word(input logic [7:0] op, a, b, c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_field_a <= a;
    in_field_b <= b;
    in_field_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    execute_word(op, a, b, c);
    words_sent++;
  endtask

  // Random word. Most use a small register and heap working set so that
  // reads see earlier writes and compares come out both ways.
  task automatic random_word(input bit straight, output logic [7:0] op, a, b, c);
    int kind;
    kind = $urandom_range(0, 99);
    op = RUN_OPS[$urandom_range(0, straight ? STRAIGHT_OPS - 1 : 10)];
    a  = 8'($urandom_range(0, 255));
    b  = 8'($urandom_range(0, 255));
    c  = 8'($urandom_range(0, 255));
    if (kind < 75) begin
      if (op != rbe_pkg::OP_JUMP) a = 8'($urandom_range(0, 7));
      if (op != rbe_pkg::OP_ITE && op != rbe_pkg::OP_PUTI) b = 8'($urandom_range(0, 7));
      if (op != rbe_pkg::OP_ITE) c = 8'($urandom_range(0, 7));
      if (op == rbe_pkg::OP_LOAD) b = 8'($urandom_range(0, 15));
      if (op == rbe_pkg::OP_STORE) a = 8'($urandom_range(0, 15));
      if (op == rbe_pkg::OP_PUTI && $urandom_range(0, 1)) b = 8'($urandom_range(0, 3));
    end else if (kind >= 92 && !straight) begin
      // undefined code; nudge off any defined one
      op = 8'($urandom_range(0, 255));
      if (op[3:0] == 4'h0 && op <= rbe_pkg::OP_JUMP) op[0] = 1'b1;
    end
  endtask

  task automatic test_data_ops();
    send_word(rbe_pkg::OP_PUTI,  8'd1,   8'hff, 8'd0);   // r1 = 255
    send_word(rbe_pkg::OP_LOAD,  8'd2,   8'd0,  8'd0);   // untouched heap reads zero
    send_word(rbe_pkg::OP_SUB,   8'd3,   8'd2,  8'd1);   // borrow through the top
    send_word(rbe_pkg::OP_ADD,   8'd4,   8'd3,  8'd3);   // carry out dropped
    send_word(rbe_pkg::OP_STORE, 8'hff,  8'd1,  8'd0);   // heap top = 0xff
    send_word(rbe_pkg::OP_LOAD,  8'd5,   8'hff, 8'd0);   // sign extends to all ones
    send_word(rbe_pkg::OP_STORE, 8'd0,   8'd3,  8'd0);   // only the low byte lands
    send_word(rbe_pkg::OP_LOAD,  8'd6,   8'd0,  8'd0);   // positive byte
    send_word(rbe_pkg::OP_GT,    8'd7,   8'd3,  8'd1);   // unsigned, large wins
    send_word(rbe_pkg::OP_GE,    8'd8,   8'd1,  8'd1);
    send_word(rbe_pkg::OP_EQ,    8'd9,   8'd1,  8'd3);
    send_word(rbe_pkg::OP_MOVE,  8'hff,  8'd5,  8'd0);   // top register
    send_word(rbe_pkg::OP_ADD,   8'd10,  8'hff, 8'd1);   // all ones + 255 wraps
  endtask

  task automatic test_branches();
    send_word(rbe_pkg::OP_ITE,  8'd0,  8'h10, 8'hfc);    // r0 is zero: else target
    send_word(rbe_pkg::OP_ITE,  8'd1,  8'hff, 8'h00);    // r1 nonzero: then target
    send_word(rbe_pkg::OP_JUMP, 8'h00, 8'd0,  8'd0);
    send_word(rbe_pkg::OP_JUMP, 8'hff, 8'd0,  8'd0);     // odd pc is legal
  endtask

  task automatic test_undefined_ops();
    foreach (UNDEFINED_OPS[i])
      send_word(UNDEFINED_OPS[i], 8'd1, 8'd2, 8'd3);
  endtask

  task automatic test_random_programs();
    logic [7:0] op, a, b, c;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      random_word(1'b0, op, a, b, c);
      send_word(op, a, b, c);
    end
    no_gaps = 1'b0;
  endtask

  // Straight-line code, the pc climbing well past the jump targets
  task automatic test_straight_run();
    logic [7:0] op, a, b, c;
    no_gaps = 1'b1;
    for (int i = 0; i < STRAIGHT_WORDS; i++) begin
      if (i % 200 == 0) no_gaps = ($urandom_range(0, 4) != 0);
      random_word(1'b1, op, a, b, c);
      send_word(op, a, b, c);
    end
    no_gaps = 1'b0;
  endtask

  // Must run last: nothing but reset clears the halted state
  task automatic test_halt();
    send_word(rbe_pkg::OP_HALT,  8'd0,  8'd0,  8'd0);
    send_word(rbe_pkg::OP_PUTI,  8'd1,  8'h55, 8'd0);
    send_word(rbe_pkg::OP_STORE, 8'd0,  8'd1,  8'd0);
    send_word(UNDEFINED_OPS[0], 8'd0, 8'd0, 8'd0);
    send_word(rbe_pkg::OP_JUMP,  8'h40, 8'd0,  8'd0);
  endtask

  // Receiver: short stalls often, long ones now and then, calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        calm_left <= $urandom_range(20, 120);
        out_stall <= 1'b0;
      end else if (roll < 6) begin
        stall_left <= $urandom_range(8, 30);
        out_stall  <= 1'b1;
      end else if (roll < 25) begin
        stall_left <= $urandom_range(0, 2);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result word against the oldest prediction
  always @(posedge clk) begin : check_results
    step_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result word with no word outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc",      32'(out_next_pc),      32'(want.next_pc));
        check_field("halted",       32'(out_halted),       32'(want.halted));
        check_field("bad_opcode",   32'(out_bad_opcode),   32'(want.bad_opcode));
        check_field("reg_written",  32'(out_reg_written),  32'(want.reg_written));
        check_field("reg_index",    32'(out_reg_index),    32'(want.reg_index));
        check_field("reg_value",    out_reg_value,         want.reg_value);
        check_field("heap_written", 32'(out_heap_written), 32'(want.heap_written));
        results_checked++;
      end
    end
  end

  initial begin
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_heap[i]) shadow_heap[i] = '0;
    shadow_pc     = '0;
    shadow_halted = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_data_ops();
    test_branches();
    test_undefined_ops();
    test_random_programs();
    test_straight_run();
    test_halt();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // anything stray after the last result
    $display("Sent %0d words (%0d undefined), checked %0d results;",
             words_sent, undefined_sent, results_checked);
    $display("data, branch and undefined corners, random code, straight run, halt.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Generous cap, well past the slowest legal run
  initial begin
    #20_000_000;
    $display("Timeout: %0d results still outstanding", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
